@@ hw/rtl/obkm_pkg.sv @@
// Shared types and codes for the order book k-way merge block.
// No dependencies; used by order_book_kway_merge.
`timescale 1ns / 1ps

package obkm_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_MERGE  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_ORDER     = 2'd2,
        ST_EMPTY     = 2'd3
    } status_code_t;

    localparam logic CFG_MERGE_DEPTH   = 1'b0;
    localparam logic CFG_VENUES_IN_USE = 1'b1;

    localparam logic [4:0] DEPTH_RESET  = 5'd16;
    localparam logic [2:0] VENUES_RESET = 3'd4;
    localparam logic [4:0] DEPTH_CAP    = 5'd16;
    localparam int         ADDR_SLOTS   = 4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        side;
        logic [1:0]  venue;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [3:0]  admit_mask;
    } req_t;

    typedef struct packed {
        logic        out_side;
        logic [31:0] level_price;
        logic [1:0]  share_venue;
        logic [31:0] share_qty;
        logic [33:0] level_total;
        logic [39:0] running_qty;
        logic [63:0] running_notional;
        logic [3:0]  level_index;
        logic        last_of_level;
        logic [1:0]  status;
        logic        last;
    } res_t;

endpackage

@@ hw/rtl/order_book_kway_merge.sv @@
// Order book k-way merge: per-venue price-level lists in one level memory, merge sequencer.
// Depends on obkm_pkg.
`timescale 1ns / 1ps

// Channel   | Handshake                      | Payload
// request   | start in, busy out             | req (obkm_pkg::req_t)
// result    | result_valid out, one cycle    | result (obkm_pkg::res_t)
// config    | cfg_valid in, cfg_ready out    | cfg_index, cfg_data
//
// Clear and append are handled in idle: busy stays low and the result appears in the cycle after start.
// A merge runs a setup state, then per merged level: a head-load pass over the venue slots that
// reads and captures each venue head that needs it, a find pass over the slots for the best price,
// a check state, the multiply, product and accumulate states, and an emit pass over the slots.
// Reset clears the list lengths and control state; the level memory is not cleared.
// The result receiver cannot stall, so results leave one per cycle as produced.
module order_book_kway_merge #(
    parameter int MAX_VENUES      = 4,
    parameter int LEVELS_PER_LIST = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  obkm_pkg::req_t   req,
    output logic             result_valid,
    output obkm_pkg::res_t   result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [4:0]       cfg_data
);

    localparam int NLISTS = 2 * MAX_VENUES;
    localparam int DEPTH  = NLISTS * LEVELS_PER_LIST;
    localparam int AW     = $clog2(DEPTH);
    localparam int LW     = $clog2(NLISTS);
    localparam int VW     = $clog2(MAX_VENUES);
    localparam int CW     = $clog2(LEVELS_PER_LIST + 1);
    localparam int SCAN_MAX = (MAX_VENUES < obkm_pkg::ADDR_SLOTS) ? MAX_VENUES
                                                                  : obkm_pkg::ADDR_SLOTS;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_LREQ, S_LCAP, S_FIND, S_CHK, S_MUL, S_PROD, S_ACC, S_EMIT
    } state_t;

    // Level memory: {price, quantity}, synchronous read.
    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;

    state_t state_reg, state_next;
    logic [4:0] depth_reg, depth_next;
    logic [2:0] venues_reg, venues_next;
    logic [CW-1:0] len_reg [NLISTS];
    logic [CW-1:0] len_next [NLISTS];
    logic [31:0] tail_reg [NLISTS];
    logic [31:0] tail_next [NLISTS];
    logic [CW-1:0] cur_reg [MAX_VENUES];
    logic [CW-1:0] cur_next [MAX_VENUES];
    logic [31:0] hp_reg [MAX_VENUES];
    logic [31:0] hp_next [MAX_VENUES];
    logic [31:0] hq_reg [MAX_VENUES];
    logic [31:0] hq_next [MAX_VENUES];
    logic [MAX_VENUES-1:0] act_reg, act_next;
    logic [MAX_VENUES-1:0] need_reg, need_next;
    logic [MAX_VENUES-1:0] match_reg, match_next;
    logic        more_reg, more_next;
    logic        side_reg, side_next;
    logic [VW-1:0] v_reg, v_next;
    logic [3:0]  lvl_reg, lvl_next;
    logic [3:0]  dlast_reg, dlast_next;
    logic        found_reg, found_next;
    logic [31:0] best_reg, best_next;
    logic [33:0] lqty_reg, lqty_next;
    logic [63:0] plo_reg, plo_next;
    logic [63:0] prod_reg, prod_next;
    logic [39:0] rqty_reg, rqty_next;
    logic [63:0] rnot_reg, rnot_next;
    logic        rv_reg, rv_next;
    obkm_pkg::res_t res_reg, res_next;

    logic [LW-1:0] a_list;
    logic [CW-1:0] a_len;
    logic [2:0]    scan;
    logic [4:0]    deff;
    logic [65:0]   prod66;
    logic [40:0]   rq_sum;
    logic [64:0]   rn_sum;
    logic          hi_match;
    logic [LW-1:0] m_list;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // Appends only happen in idle and reads only during a merge, so the ports never collide.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {req.price, req.quantity};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        venues_next = venues_reg;
        len_next    = len_reg;
        tail_next   = tail_reg;
        cur_next    = cur_reg;
        hp_next     = hp_reg;
        hq_next     = hq_reg;
        act_next    = act_reg;
        need_next   = need_reg;
        match_next  = match_reg;
        more_next   = more_reg;
        side_next   = side_reg;
        v_next      = v_reg;
        lvl_next    = lvl_reg;
        dlast_next  = dlast_reg;
        found_next  = found_reg;
        best_next   = best_reg;
        lqty_next   = lqty_reg;
        plo_next    = plo_reg;
        prod_next   = prod_reg;
        rqty_next   = rqty_reg;
        rnot_next   = rnot_reg;
        rv_next     = 1'b0;
        res_next    = res_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        prod66      = '0;
        rq_sum      = '0;
        rn_sum      = '0;
        hi_match    = 1'b0;

        a_list = LW'({req.venue, req.side});
        a_len  = len_reg[a_list];
        m_list = LW'({v_reg, side_reg});

        if (venues_reg > 3'(SCAN_MAX))
            scan = 3'(SCAN_MAX);
        else
            scan = venues_reg;
        if (depth_reg == 5'd0)
            deff = 5'd1;
        else if (depth_reg > obkm_pkg::DEPTH_CAP)
            deff = obkm_pkg::DEPTH_CAP;
        else
            deff = depth_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                obkm_pkg::CFG_MERGE_DEPTH:   depth_next  = cfg_data;
                obkm_pkg::CFG_VENUES_IN_USE: venues_next = cfg_data[2:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    res_next.last = 1'b1;
                    unique case (req.cmd)
                        obkm_pkg::CMD_CLEAR:
                        begin
                            rv_next = 1'b1;
                            for (int i = 0; i < NLISTS; i++)
                                len_next[i] = '0;
                        end
                        obkm_pkg::CMD_APPEND:
                        begin
                            rv_next              = 1'b1;
                            res_next.out_side    = req.side;
                            res_next.level_price = req.price;
                            res_next.share_venue = req.venue;
                            res_next.share_qty   = req.quantity;
                            if (int'(req.venue) >= MAX_VENUES ||
                                int'(a_len) >= LEVELS_PER_LIST)
                                res_next.status = obkm_pkg::ST_FULL;
                            else if (a_len != '0 &&
                                     (req.side == 1'b0 ? req.price >= tail_reg[a_list]
                                                       : req.price <= tail_reg[a_list]))
                                res_next.status = obkm_pkg::ST_ORDER;
                            else
                            begin
                                res_next.status   = obkm_pkg::ST_OK;
                                wr_en             = 1'b1;
                                wr_addr           = AW'(int'(a_list) * LEVELS_PER_LIST
                                                        + int'(a_len));
                                len_next[a_list]  = a_len + CW'(1);
                                tail_next[a_list] = req.price;
                            end
                        end
                        obkm_pkg::CMD_MERGE:
                        begin
                            side_next = req.side;
                            for (int i = 0; i < MAX_VENUES; i++)
                            begin
                                cur_next[i] = '0;
                                act_next[i] = (i < int'(scan)) && req.admit_mask[i % 4] &&
                                              (len_reg[LW'(2 * i) | LW'(req.side)] != '0);
                            end
                            state_next = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT:
            begin
                need_next  = act_reg;
                dlast_next = 4'(deff - 5'd1);
                lvl_next   = '0;
                rqty_next  = '0;
                rnot_next  = '0;
                v_next     = '0;
                state_next = S_LREQ;
            end
            S_LREQ:
            begin
                if (need_reg[v_reg])
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(int'(m_list) * LEVELS_PER_LIST + int'(cur_reg[v_reg]));
                    state_next = S_LCAP;
                end
                else if (int'(v_reg) == MAX_VENUES - 1)
                begin
                    v_next     = '0;
                    found_next = 1'b0;
                    state_next = S_FIND;
                end
                else
                    v_next = v_reg + VW'(1);
            end
            S_LCAP:
            begin
                hp_next[v_reg]   = rd_data_reg[63:32];
                hq_next[v_reg]   = rd_data_reg[31:0];
                need_next[v_reg] = 1'b0;
                if (int'(v_reg) == MAX_VENUES - 1)
                begin
                    v_next     = '0;
                    found_next = 1'b0;
                    state_next = S_FIND;
                end
                else
                begin
                    v_next     = v_reg + VW'(1);
                    state_next = S_LREQ;
                end
            end
            S_FIND:
            begin
                // Track the best price and the sum of quantities quoted at it in one pass.
                if (act_reg[v_reg])
                begin
                    if (!found_reg || (side_reg == 1'b0 ? hp_reg[v_reg] > best_reg
                                                        : hp_reg[v_reg] < best_reg))
                    begin
                        found_next = 1'b1;
                        best_next  = hp_reg[v_reg];
                        lqty_next  = 34'(hq_reg[v_reg]);
                    end
                    else if (hp_reg[v_reg] == best_reg)
                        lqty_next = lqty_reg + 34'(hq_reg[v_reg]);
                end
                if (int'(v_reg) == MAX_VENUES - 1)
                    state_next = S_CHK;
                else
                    v_next = v_reg + VW'(1);
            end
            S_CHK:
            begin
                if (!found_reg)
                begin
                    // Only possible on the first level: no admitted venue holds a level.
                    res_next          = '0;
                    res_next.out_side = side_reg;
                    res_next.status   = obkm_pkg::ST_EMPTY;
                    res_next.last     = 1'b1;
                    rv_next           = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                plo_next = 64'(best_reg) * 64'(lqty_reg[31:0]);
                more_next = 1'b0;
                for (int i = 0; i < MAX_VENUES; i++)
                begin
                    match_next[i] = act_reg[i] && (hp_reg[i] == best_reg);
                    if (act_reg[i] && hp_reg[i] != best_reg)
                        more_next = 1'b1;
                    if (act_reg[i] && hp_reg[i] == best_reg &&
                        (cur_reg[i] + CW'(1)) < len_reg[LW'(2 * i) | LW'(side_reg)])
                        more_next = 1'b1;
                end
                state_next = S_PROD;
            end
            S_PROD:
            begin
                prod66 = 66'(plo_reg) +
                         ({32'd0, 34'(best_reg) * 34'(lqty_reg[33:32])} << 32);
                if (prod66[65:64] != 2'b00)
                    prod_next = '1;
                else
                    prod_next = prod66[63:0];
                state_next = S_ACC;
            end
            S_ACC:
            begin
                rq_sum = 41'(rqty_reg) + 41'(lqty_reg);
                rqty_next = rq_sum[40] ? '1 : rq_sum[39:0];
                rn_sum = 65'(rnot_reg) + 65'(prod_reg);
                rnot_next = rn_sum[64] ? '1 : rn_sum[63:0];
                v_next = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                for (int i = 0; i < MAX_VENUES; i++)
                    if (i > int'(v_reg) && match_reg[i])
                        hi_match = 1'b1;
                if (match_reg[v_reg])
                begin
                    rv_next                   = 1'b1;
                    res_next.out_side         = side_reg;
                    res_next.level_price      = best_reg;
                    res_next.share_venue      = 2'(v_reg);
                    res_next.share_qty        = hq_reg[v_reg];
                    res_next.level_total      = lqty_reg;
                    res_next.running_qty      = rqty_reg;
                    res_next.running_notional = rnot_reg;
                    res_next.level_index      = lvl_reg;
                    res_next.last_of_level    = !hi_match;
                    res_next.status           = obkm_pkg::ST_OK;
                    res_next.last             = !hi_match &&
                                                (lvl_reg == dlast_reg || !more_reg);
                    cur_next[v_reg]  = cur_reg[v_reg] + CW'(1);
                    act_next[v_reg]  = (cur_reg[v_reg] + CW'(1)) < len_reg[m_list];
                    need_next[v_reg] = (cur_reg[v_reg] + CW'(1)) < len_reg[m_list];
                end
                if (int'(v_reg) == MAX_VENUES - 1)
                begin
                    v_next = '0;
                    if (lvl_reg == dlast_reg || !more_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        lvl_next   = lvl_reg + 4'd1;
                        state_next = S_LREQ;
                    end
                end
                else
                    v_next = v_reg + VW'(1);
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            depth_reg  <= obkm_pkg::DEPTH_RESET;
            venues_reg <= obkm_pkg::VENUES_RESET;
            for (int i = 0; i < NLISTS; i++)
                len_reg[i] <= '0;
            for (int i = 0; i < MAX_VENUES; i++)
                cur_reg[i] <= '0;
            act_reg   <= '0;
            need_reg  <= '0;
            match_reg <= '0;
            more_reg  <= 1'b0;
            v_reg     <= '0;
            lvl_reg   <= '0;
            dlast_reg <= '0;
            found_reg <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            venues_reg <= venues_next;
            len_reg    <= len_next;
            cur_reg    <= cur_next;
            act_reg    <= act_next;
            need_reg   <= need_next;
            match_reg  <= match_next;
            more_reg   <= more_next;
            v_reg      <= v_next;
            lvl_reg    <= lvl_next;
            dlast_reg  <= dlast_next;
            found_reg  <= found_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        hp_reg   <= hp_next;
        hq_reg   <= hq_next;
        side_reg <= side_next;
        best_reg <= best_next;
        lqty_reg <= lqty_next;
        plo_reg  <= plo_next;
        prod_reg <= prod_next;
        rqty_reg <= rqty_next;
        rnot_reg <= rnot_next;
        res_reg  <= res_next;
    end

endmodule

@@ tb/order_book_kway_merge_tb.sv @@
// Self-checking testbench for order_book_kway_merge: random and directed
// append, clear and merge requests are checked against an in-bench price book.
// Depends on obkm_pkg and order_book_kway_merge.
`timescale 1ns / 1ps

module order_book_kway_merge_tb;

    localparam int NV = 4;
    localparam int NL = 64;
    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    obkm_pkg::req_t req = '0;
    logic result_valid;
    obkm_pkg::res_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;

    order_book_kway_merge u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Book mirror used to predict the shares of each merge.
    logic [31:0] book_price [NV][2][NL];
    logic [31:0] book_qty [NV][2][NL];
    int book_len [NV][2];
    logic [4:0] depth_reg;
    logic [2:0] venues_reg;

    obkm_pkg::req_t pending_reqs [$];
    obkm_pkg::res_t expected_shares [$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit calm = 1'b0;

    function automatic obkm_pkg::res_t blank_result();
        obkm_pkg::res_t r;
        r = '0;
        return r;
    endfunction

    function automatic void add_expected(input obkm_pkg::res_t o);
        expected_shares = {expected_shares, o};
    endfunction

    function automatic void add_pending(input obkm_pkg::req_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    task automatic predict_request(input obkm_pkg::req_t r);
        obkm_pkg::res_t o;
        int n, scan, depth, k, first;
        int cur [NV];
        bit act [NV];
        bit found;
        logic [31:0] best, p;
        logic [33:0] lqty;
        logic [39:0] rq;
        logic [63:0] rn, prod;
        logic [127:0] wide;
        logic [40:0] rsum;
        logic [64:0] nsum;
        o = blank_result();
        case (r.cmd)
            obkm_pkg::CMD_CLEAR:
            begin
                for (int v = 0; v < NV; v++)
                begin
                    book_len[v][0] = 0;
                    book_len[v][1] = 0;
                end
                o.last = 1'b1;
                add_expected(o);
            end
            obkm_pkg::CMD_APPEND:
            begin
                o.out_side = r.side;
                o.level_price = r.price;
                o.share_venue = r.venue;
                o.share_qty = r.quantity;
                o.last = 1'b1;
                o.status = obkm_pkg::ST_OK;
                n = book_len[r.venue][r.side];
                if (n >= NL) o.status = obkm_pkg::ST_FULL;
                else
                begin
                    if (n > 0)
                    begin
                        p = book_price[r.venue][r.side][n-1];
                        if (r.side == 1'b0 ? r.price >= p : r.price <= p)
                            o.status = obkm_pkg::ST_ORDER;
                    end
                    if (o.status == obkm_pkg::ST_OK)
                    begin
                        book_price[r.venue][r.side][n] = r.price;
                        book_qty[r.venue][r.side][n] = r.quantity;
                        book_len[r.venue][r.side] = n + 1;
                    end
                end
                add_expected(o);
            end
            obkm_pkg::CMD_MERGE:
            begin
                scan = (int'(venues_reg) > NV) ? NV : int'(venues_reg);
                depth = (int'(depth_reg) < 1) ? 1 :
                        (int'(depth_reg) > 16) ? 16 : int'(depth_reg);
                for (int v = 0; v < NV; v++)
                begin
                    cur[v] = 0;
                    act[v] = (v < scan) && r.admit_mask[v] && book_len[v][r.side] > 0;
                end
                rq = '0;
                rn = '0;
                k = 0;
                for (int lvl = 0; lvl < depth; lvl++)
                begin
                    found = 1'b0;
                    best = '0;
                    for (int v = 0; v < scan; v++)
                        if (act[v])
                        begin
                            p = book_price[v][r.side][cur[v]];
                            if (!found || (r.side == 1'b0 ? p > best : p < best))
                            begin
                                best = p;
                                found = 1'b1;
                            end
                        end
                    if (!found) break;
                    first = expected_shares.size();
                    lqty = '0;
                    for (int v = 0; v < scan; v++)
                        if (act[v] && book_price[v][r.side][cur[v]] == best)
                        begin
                            o = blank_result();
                            o.out_side = r.side;
                            o.level_price = best;
                            o.share_venue = v[1:0];
                            o.share_qty = book_qty[v][r.side][cur[v]];
                            o.level_index = lvl[3:0];
                            lqty = lqty + 34'(o.share_qty);
                            add_expected(o);
                            k++;
                            cur[v]++;
                            act[v] = cur[v] < book_len[v][r.side];
                        end
                    rsum = 41'(rq) + 41'(lqty);
                    rq = rsum[40] ? '1 : rsum[39:0];
                    wide = 128'(best) * 128'(lqty);
                    prod = (wide[127:64] != 0) ? '1 : wide[63:0];
                    nsum = 65'(rn) + 65'(prod);
                    rn = nsum[64] ? '1 : nsum[63:0];
                    for (int i = first; i < expected_shares.size(); i++)
                    begin
                        expected_shares[i].level_total = lqty;
                        expected_shares[i].running_qty = rq;
                        expected_shares[i].running_notional = rn;
                    end
                    expected_shares[$].last_of_level = 1'b1;
                end
                if (k == 0)
                begin
                    o = blank_result();
                    o.out_side = r.side;
                    o.status = obkm_pkg::ST_EMPTY;
                    o.last = 1'b1;
                    add_expected(o);
                end
                else expected_shares[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Request driver: start stays high across back-to-back requests.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_request(req);
                void'(pending_reqs.pop_front());
            end
            if ((!start || !busy) && !hold_off)
            begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 19))
                begin
                    start <= 1'b1;
                    req <= pending_reqs[0];
                end
                else
                    start <= 1'b0;
            end
            else if (hold_off && !busy)
                start <= 1'b0;
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        obkm_pkg::res_t e;
        if (rst_n && result_valid)
        begin
            if (expected_shares.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", result);
            end
            else
            begin
                e = expected_shares.pop_front();
                if (result !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", e, result);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request, result or write.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("order_book_kway_merge test failed");
            $finish;
        end
    end

    function automatic obkm_pkg::req_t make_req(input int c, input int s, input int v,
                                                input logic [31:0] p, input logic [31:0] q,
                                                input int m);
        obkm_pkg::req_t r;
        r.cmd = 2'(c);
        r.side = 1'(s);
        r.venue = 2'(v);
        r.price = p;
        r.quantity = q;
        r.admit_mask = 4'(m);
        return r;
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || start) @(posedge clk);
        while (expected_shares.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == obkm_pkg::CFG_MERGE_DEPTH) depth_reg = val;
        else venues_reg = val[2:0];
    endtask

    // Builds a random well-formed book: per list a strictly ordered price run.
    task automatic fill_book(input int levels, input int spread);
        logic [31:0] base, p;
        int n_lvls;
        add_pending(make_req(obkm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
        for (int s = 0; s < 2; s++)
            for (int v = 0; v < NV; v++)
            begin
                base = s ? 32'd1000 : 32'd1100;
                p = base + $urandom_range(spread);
                n_lvls = $urandom_range(levels);
                for (int i = 0; i < n_lvls; i++)
                begin
                    add_pending(make_req(obkm_pkg::CMD_APPEND, s, v, p,
                        ($urandom_range(9) == 0) ? $urandom : $urandom_range(500), 0));
                    p = s ? p + 1 + $urandom_range(spread) : p - 1 - $urandom_range(spread);
                end
            end
    endtask

    initial
    begin
        int phase_items;
        depth_reg = obkm_pkg::DEPTH_RESET;
        venues_reg = obkm_pkg::VENUES_RESET;
        for (int v = 0; v < NV; v++)
        begin
            book_len[v][0] = 0;
            book_len[v][1] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        calm = 1'b1;
        // Directed: extreme fields, order violations, saturation, empty merges, unused cmd.
        add_pending(make_req(obkm_pkg::CMD_MERGE, 0, 0, 0, 0, 15));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 0, 0, 32'hFFFFFFFF, 5, 0));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 0, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 0));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 0, 2, 32'hFFFFFFFF, 32'hFFFFFFFF, 0));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 0, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 0));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 0, 3, 32'hFFFFFFFE, 32'hFFFFFFFF, 0));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 0, 3, 32'hFFFFFFFF, 1, 0));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 1, 2, 0, 0, 0));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 1, 2, 0, 7, 0));
        add_pending(make_req(obkm_pkg::CMD_APPEND, 1, 1, 3, 9, 0));
        add_pending(make_req(obkm_pkg::CMD_NONE, 1, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 15));
        add_pending(make_req(obkm_pkg::CMD_MERGE, 0, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 15));
        add_pending(make_req(obkm_pkg::CMD_MERGE, 1, 0, 0, 0, 15));
        add_pending(make_req(obkm_pkg::CMD_MERGE, 1, 0, 0, 0, 0));
        add_pending(make_req(obkm_pkg::CMD_MERGE, 0, 0, 0, 0, 5));
        for (int i = 0; i < 65; i++)
            add_pending(make_req(obkm_pkg::CMD_APPEND, 1, 0, 100 + i, i, 0));
        add_pending(make_req(obkm_pkg::CMD_MERGE, 1, 0, 0, 0, 15));
        add_pending(make_req(obkm_pkg::CMD_CLEAR, 1, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 15));
        add_pending(make_req(obkm_pkg::CMD_MERGE, 0, 0, 0, 0, 15));
        drain();
        calm = 1'b0;
        // Random phases across register settings, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(obkm_pkg::CFG_MERGE_DEPTH, 5'd1);
                    write_reg(obkm_pkg::CFG_VENUES_IN_USE, 5'd0);
                end
                1:
                begin
                    write_reg(obkm_pkg::CFG_MERGE_DEPTH, 5'd16);
                    write_reg(obkm_pkg::CFG_VENUES_IN_USE, 5'd4);
                end
                2:
                begin
                    write_reg(obkm_pkg::CFG_MERGE_DEPTH, 5'd0);
                    write_reg(obkm_pkg::CFG_VENUES_IN_USE, 5'd7);
                end
                3:
                begin
                    write_reg(obkm_pkg::CFG_MERGE_DEPTH, 5'd31);
                    write_reg(obkm_pkg::CFG_VENUES_IN_USE, 5'd2);
                end
                default:
                begin
                    write_reg(obkm_pkg::CFG_MERGE_DEPTH, 5'($urandom_range(31)));
                    write_reg(obkm_pkg::CFG_VENUES_IN_USE, 5'($urandom_range(7)));
                end
            endcase
            calm = (ph == 5);
            fill_book(4, (ph % 2) ? 1 : 3);
            phase_items = 6;
            for (int i = 0; i < phase_items; i++)
            begin
                if ($urandom_range(4) == 0)
                    add_pending(make_req($urandom_range(3), $urandom_range(1),
                        $urandom_range(3), $urandom, $urandom, $urandom_range(15)));
                else
                    add_pending(make_req(obkm_pkg::CMD_MERGE, $urandom_range(1),
                        $urandom_range(3), $urandom, $urandom, $urandom_range(15)));
            end
            if (ph == 3)
            begin
                while (pending_reqs.size() > 3) @(posedge clk);
                hold_off = 1'b1;
                while (start || expected_shares.size() != 0) @(posedge clk);
                hold_off = 1'b0;
            end
        end
        drain();
        if (mismatches == 0)
            $display("order_book_kway_merge test passed");
        else
            $display("order_book_kway_merge test failed");
        $finish;
    end

endmodule
